[design/drwc_pkg.sv]
// ----------------------------------------------------------------------------
// drwc_pkg - shared types and constants for the DTLS replay window check
// Field widths, verdict codes and register map of the configuration port.
// ----------------------------------------------------------------------------
package drwc_pkg;

  // Payload field widths
  localparam int EPOCH_W   = 16;
  localparam int NUMBER_W  = 48;
  localparam int VERDICT_W = 2;

  typedef logic [EPOCH_W-1:0]   epoch_t;
  typedef logic [NUMBER_W-1:0]  number_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  // Verdict codes
  localparam verdict_t V_ACCEPT = 2'd0;
  localparam verdict_t V_EPOCH  = 2'd1;
  localparam verdict_t V_OLD    = 2'd2;
  localparam verdict_t V_REPLAY = 2'd3;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index (paddr[2])
  localparam logic REG_EXPECTED_EPOCH = 1'b0;

endpackage

[design/dtls_replay_window_check.sv]
// ----------------------------------------------------------------------------
// dtls_replay_window_check - DTLS anti-replay sliding window
// Checks each record's epoch and sequence number against a missing-packet
// bitmap and returns accept, wrong epoch, too old or replay.
// ----------------------------------------------------------------------------
// Pipeline: input register, then verdict register; the window update lands on
//   the same edge as the verdict.
// Throughput: 1 transaction per cycle unless out_ready stalls the verdict
//   register; the state update (compare, subtract and one barrel shift of the bitmap) is combinational.
// Reset (rst_n, synchronous, active low): pipeline empty, window not started,
//   next expected number 0, bitmap all ones, expected epoch 0.
module dtls_replay_window_check
  import drwc_pkg::*;
#(
  parameter int WINDOW_BITS = 64,
  parameter int SEQ_BITS    = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [EPOCH_W-1:0]   in_record_epoch,
  input  logic [NUMBER_W-1:0]  in_record_number,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VERDICT_W-1:0] out_verdict,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  output logic [APB_DW-1:0]    prdata,
  output logic                 pready
);

  localparam int IDX_W = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
  localparam int NE_W  = SEQ_BITS + 1;

  localparam logic [WINDOW_BITS-1:0] WIN_ONES = {WINDOW_BITS{1'b1}};
  localparam logic [NE_W-1:0] WIN_SIZE  = NE_W'(WINDOW_BITS);
  localparam logic [NE_W-1:0] WIN_LIMIT = NE_W'(WINDOW_BITS + 1);
  localparam logic [NE_W-1:0] NE_ONE    = NE_W'(1);
  localparam logic [NE_W-1:0] NE_TWO    = NE_W'(2);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [EPOCH_W-1:0] epoch_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= '0;
    end else if (cfg_wr && (paddr[2] == REG_EXPECTED_EPOCH)) begin
      epoch_r <= pwdata[EPOCH_W-1:0];
    end
  end

  // Read back the epoch; any other address reads zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_EXPECTED_EPOCH) begin
      prdata = APB_DW'(epoch_r);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register (s1) feeds the verdict register (out).
  // s1 advances whenever the verdict register is empty or being drained.
  // --------------------------------------------------------------------------
  logic                s1_vld_r;
  logic [EPOCH_W-1:0]  s1_epoch_r;
  logic [SEQ_BITS-1:0] s1_seq_r;
  logic                out_vld_r;
  verdict_t            out_verdict_r;
  logic                adv;

  assign adv       = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_verdict = out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  // Payload: capture only the low SEQ_BITS of the number
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_epoch_r <= in_record_epoch;
      s1_seq_r   <= in_record_number[SEQ_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Window state and verdict logic
  // --------------------------------------------------------------------------
  logic                   started_r, started_nxt;
  logic [NE_W-1:0]        ne_r, ne_nxt;
  logic [WINDOW_BITS-1:0] map_r, map_nxt;
  verdict_t               verdict_nxt;

  logic [NE_W-1:0]        seq_ext;
  logic                   ahead;     // seq at or beyond next expected
  logic [NE_W-1:0]        gap;       // seq - next expected
  logic [NE_W-1:0]        back;      // next expected - seq
  logic [IDX_W-1:0]       gap_idx;
  logic [IDX_W-1:0]       bit_idx;
  logic [WINDOW_BITS-1:0] shifted;
  logic [WINDOW_BITS-1:0] fill;

  always_comb begin
    seq_ext = {1'b0, s1_seq_r};
    ahead   = seq_ext >= ne_r;
    gap     = seq_ext - ne_r;
    back    = ne_r - seq_ext;
    gap_idx = gap[IDX_W-1:0];
    bit_idx = IDX_W'(back - NE_TWO);

    // Move the window on by gap+1 and mark the skipped numbers missing.
    // A gap of one less than the window drops every old bit.
    shifted = (map_r << 1) << gap_idx;
    fill    = ~(WIN_ONES << gap_idx);

    started_nxt = started_r;
    ne_nxt      = ne_r;
    map_nxt     = map_r;
    verdict_nxt = V_ACCEPT;

    priority if (s1_epoch_r != epoch_r) begin
      verdict_nxt = V_EPOCH;
    end else if (!started_r) begin
      // First record seeds the window
      started_nxt = 1'b1;
      ne_nxt      = seq_ext + NE_ONE;
      map_nxt     = WIN_ONES;
    end else if (ahead) begin
      ne_nxt = seq_ext + NE_ONE;
      if (gap >= WIN_SIZE) begin
        map_nxt = WIN_ONES;
      end else begin
        map_nxt = shifted | fill;
      end
    end else if (back > WIN_LIMIT) begin
      verdict_nxt = V_OLD;
    end else if (back == NE_ONE) begin
      // Newest accepted number seen again
      verdict_nxt = V_REPLAY;
    end else if (!map_r[bit_idx]) begin
      verdict_nxt = V_REPLAY;
    end else begin
      // Late arrival inside the window: clear its missing bit
      map_nxt = map_r & ~(WINDOW_BITS'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      ne_r      <= '0;
      map_r     <= WIN_ONES;
      out_vld_r <= 1'b0;
    end else begin
      if (adv) begin
        started_r <= started_nxt;
        ne_r      <= ne_nxt;
        map_r     <= map_nxt;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_verdict_r <= verdict_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Before the first record the window holds its reset contents
  a_idle_window: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (map_r == WIN_ONES) && (ne_r == '0))
    else $error("window changed before the first accepted record");

  // Once started, next expected is always past some received number
  a_ne_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (ne_r != '0))
    else $error("next expected is zero after the window started");

  // A refused record leaves the window untouched
  a_refuse_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (verdict_nxt != V_ACCEPT)) |=> $stable(ne_r) && $stable(map_r)
      && $stable(started_r))
    else $error("window state changed on a refused record");

  // An empty verdict register never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled while result register was empty");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for dtls_replay_window_check
// Streams DTLS record headers through the anti-replay window and compares
// every verdict against a cycle-free model of the window that the bench
// updates as each input transaction is taken. The expected epoch is
// reprogrammed over the APB port between traffic bursts.
// ----------------------------------------------------------------------------
module tb
  import drwc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction anywhere
  localparam int PAUSE_EVERY = 150;   // records between drain pauses
  localparam int BURST_LEN   = 170;   // random records per epoch setting

  typedef struct packed {
    epoch_t  epoch;
    number_t number;
  } record_t;

  // --------------------------------------------------------------------------
  // DUT connections; everything driven by the bench starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_ready;
  logic [EPOCH_W-1:0]   in_record_epoch  = '0;
  logic [NUMBER_W-1:0]  in_record_number = '0;
  logic                 out_valid;
  logic                 out_ready        = 1'b0;
  logic [VERDICT_W-1:0] out_verdict;
  logic                 psel             = 1'b0;
  logic                 penable          = 1'b0;
  logic                 pwrite           = 1'b0;
  logic [APB_AW-1:0]    paddr            = '0;
  logic [APB_DW-1:0]    pwdata           = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  dtls_replay_window_check u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_record_epoch  (in_record_epoch),
    .in_record_number (in_record_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_verdict      (out_verdict),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  record_t  pending_records[$];    // headers waiting to be driven
  verdict_t expected_verdicts[$];  // verdicts owed by the DUT, oldest first
  int       errors        = 0;
  int       records_taken = 0;
  int       stall_cycles  = 0;
  bit       no_idle       = 1'b0;  // both sides run flat out while set
  bit       draining      = 1'b0;  // sender holds off until all verdicts are in
  record_t  next_record;
  verdict_t want;

  // Window model: the bench's own copy of the register and window state.
  epoch_t             cfg_epoch = '0;
  bit                 win_open  = 1'b0;
  logic [NUMBER_W:0]  next_num  = '0;   // one past the newest accepted number
  logic [63:0]        miss_map  = '1;   // bit i set: next_num-2-i not yet seen

  // Stimulus-side tracker of the newest number handed out at the live epoch.
  number_t gen_top = '0;

  // --------------------------------------------------------------------------
  // Window model: return the verdict for one header and advance the window
  // --------------------------------------------------------------------------
  function automatic verdict_t judge_record(input epoch_t e, input number_t n);
    logic [63:0] seq;
    logic [63:0] nx;
    logic [63:0] gap;
    logic [63:0] bit_sel;
    seq = 64'(n);
    nx  = 64'(next_num);
    // Wrong epoch never touches the window, not even before the first record.
    if (e != cfg_epoch) return V_EPOCH;
    // First good record seeds the window with every slot still missing.
    if (!win_open) begin
      win_open = 1'b1;
      next_num = NUMBER_W'(seq) + 1'b1;
      miss_map = '1;
      return V_ACCEPT;
    end
    if (seq == nx) begin
      miss_map = miss_map << 1;
      next_num = next_num + 1'b1;
      return V_ACCEPT;
    end
    // Below the bottom of the window.
    if (seq + 64'd65 < nx) return V_OLD;
    if (seq < nx) begin
      // The newest accepted number is known seen, it has no map slot.
      if (seq + 64'd1 == nx) return V_REPLAY;
      bit_sel = 64'd1 << (nx - seq - 64'd2);
      if ((miss_map & bit_sel) == 64'd0) return V_REPLAY;
      miss_map = miss_map & ~bit_sel;
      return V_ACCEPT;
    end
    // Forward jump: shift by gap+1 and mark skipped numbers missing.
    gap = seq - nx;
    if (gap >= 64'd64) begin
      miss_map = '1;
    end else if (gap == 64'd63) begin
      miss_map = {1'b0, {63{1'b1}}};
    end else begin
      miss_map = (miss_map << (gap + 64'd1)) | ((64'd1 << gap) - 64'd1);
    end
    next_num = NUMBER_W'(seq) + 1'b1;
    return V_ACCEPT;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one header per input transaction, random idle cycles
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(judge_record(in_record_epoch, in_record_number));
        records_taken++;
        // Periodically starve the DUT until the result side has caught up.
        if (records_taken % PAUSE_EVERY == PAUSE_EVERY / 2) draining = 1'b1;
      end
      if (draining && expected_verdicts.size() == 0) draining = 1'b0;

      if (in_valid && !in_ready) begin
        // hold the current transaction and its payload
      end else if (draining || pending_records.size() == 0 ||
                   (!no_idle && $urandom_range(0, 99) < 20)) begin
        in_valid <= 1'b0;
      end else begin
        next_record = pending_records.pop_front();
        in_valid         <= 1'b1;
        in_record_epoch  <= next_record.epoch;
        in_record_number <= next_record.number;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each verdict against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: verdict with nothing pending: expected none, actual %0d",
                   $time, out_verdict);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict !== want) begin
            errors++;
            $display("%0t: verdict mismatch: expected %0d, actual %0d",
                     $time, want, out_verdict);
          end
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 20);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up after a long stretch with no transaction at all
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("dtls_replay_window_check verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Queue one header; track the newest number sent at the live epoch.
  task automatic push_record(input epoch_t e, input number_t n);
    record_t r;
    r.epoch  = e;
    r.number = n;
    pending_records.push_back(r);
    if (e == cfg_epoch && n > gen_top) gen_top = n;
  endtask

  // Write the expected epoch, then read it back over the same port.
  task automatic program_epoch(input epoch_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({REG_EXPECTED_EPOCH, 2'b00});
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_epoch = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[EPOCH_W-1:0] !== value) begin
      errors++;
      $display("%0t: epoch readback mismatch: expected %0h, actual %0h",
               $time, value, prdata[EPOCH_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic, mostly clustered around the window edge so that
  // in-window, replay and forward-shift paths all get heavy use.
  task automatic queue_random_records(input int count);
    int      pick;
    number_t n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // wrong epoch with a fully random number
        push_record(cfg_epoch ^ epoch_t'($urandom_range(1, 65535)),
                    number_t'({$urandom(), $urandom()}));
      end else begin
        if (pick < 45)      n = gen_top + 1'b1;
        else if (pick < 70) n = gen_top - $urandom_range(0, 66);
        else if (pick < 85) n = gen_top + $urandom_range(2, 64);
        else if (pick < 90) n = gen_top + $urandom_range(65, 1 << 20);
        else if (pick < 95) n = number_t'({$urandom(), $urandom()}) % (gen_top - 48'd66);
        else                n = gen_top;
        push_record(cfg_epoch, n);
      end
    end
  endtask

  // Sample on the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    while (pending_records.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    number_t top_num;
    epoch_t  burst_epochs[4];
    top_num      = {NUMBER_W{1'b1}};
    burst_epochs = '{16'hFFFF, epoch_t'($urandom_range(2, 65534)), 16'h0001, 16'h8000};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner cases at epoch 0.
    program_epoch(16'h0000);
    push_record(16'h0005, 48'd10);         // wrong epoch before the first record
    push_record(16'h0000, 48'd100);        // seed the window
    push_record(16'h0000, 48'd100);        // newest repeated: replay
    push_record(16'h0000, 48'd101);        // exactly the expected number
    push_record(16'h0000, 48'd99);         // inside the window, first time
    push_record(16'h0000, 48'd99);         // inside the window, again
    push_record(16'h0000, 48'd36);         // one below the bottom: too old
    push_record(16'h0000, 48'd37);         // bottom slot of the window
    push_record(16'h0000, 48'd165);        // gap of window size minus one
    push_record(16'h0000, 48'd230);        // gap of exactly window size
    push_record(16'h0000, 48'd232);        // gap of one
    push_record(16'h0000, 48'd233);
    push_record(16'h0000, 48'd0);          // far behind
    push_record(16'hFFFF, top_num);        // wrong epoch, all-ones number
    push_record(16'h0000, 48'h8000_0000_0005);  // huge forward jump
    wait_drained();

    // Random bursts across several epoch settings; one burst with no idling.
    foreach (burst_epochs[p]) begin
      program_epoch(burst_epochs[p]);
      no_idle = (p == 2);
      queue_random_records(BURST_LEN);
      wait_drained();
      no_idle = 1'b0;
    end

    // End of the number space: after the top number nothing newer exists.
    program_epoch(16'h0000);
    push_record(16'h0000, top_num);
    push_record(16'h0000, top_num);
    push_record(16'h0000, top_num - 48'd1);
    push_record(16'h0000, top_num - 48'd1);
    push_record(16'h0000, top_num - 48'd64);   // bottom slot
    push_record(16'h0000, top_num - 48'd65);   // just below the window
    push_record(16'h0000, 48'd0);
    push_record(16'h1234, top_num);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("dtls_replay_window_check verification clean");
    end else begin
      $display("dtls_replay_window_check verification failed");
    end
    $finish;
  end

endmodule
